// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sfcrc_pkg.sv =====
// Package: CRC-8 nibble table, update function and frame constants.
package sfcrc_pkg;

    // Register indexes on the configuration port
    localparam logic REG_CHECK_EN = 1'b0;
    localparam logic REG_INIT_VAL = 1'b1;

    // Reset values of the configuration registers
    localparam logic       CHECK_EN_RST = 1'b1;
    localparam logic [7:0] CRC_INIT_RST = 8'hFF;

    // Frame kinds
    localparam logic KIND_MEAS   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Byte positions within a frame
    localparam logic [2:0] POS_W1_HI  = 3'd0;
    localparam logic [2:0] POS_W1_LO  = 3'd1;
    localparam logic [2:0] POS_W1_CRC = 3'd2;
    localparam logic [2:0] POS_W2_HI  = 3'd3;
    localparam logic [2:0] POS_W2_LO  = 3'd4;
    localparam logic [2:0] POS_W2_CRC = 3'd5;

    typedef logic [7:0] t_byte;

    // Polynomial 0x31 table, one entry per nibble value
    localparam t_byte NIBBLE_TAB [16] = '{
        8'h00, 8'h31, 8'h62, 8'h53, 8'hc4, 8'hf5, 8'ha6, 8'h97,
        8'hb9, 8'h88, 8'hdb, 8'hea, 8'h7d, 8'h4c, 8'h1f, 8'h2e
    };

    // One byte of CRC-8, MSB first, two nibble lookups
    function automatic t_byte crc8_update(input t_byte crc, input t_byte data);
        t_byte c;
        logic [3:0] idx;
        idx = crc[7:4] ^ data[7:4];
        c   = {crc[3:0], 4'h0} ^ NIBBLE_TAB[idx];
        idx = c[7:4] ^ data[3:0];
        c   = {c[3:0], 4'h0} ^ NIBBLE_TAB[idx];
        return c;
    endfunction

endpackage

// ===== sv/sensor_frame_crc8_checker.sv =====
// Top level: sensor frame assembler with per-word CRC-8 check.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one response byte per request,
//   with i_frame_start marking the first byte of a frame and i_mode giving
//   its kind there (0 = measurement, six bytes; 1 = status, three bytes).
//   Output channel (o_valid / i_stall) carries one request per completed
//   frame: both words, the CRC verdict and the frame kind.
//   Configuration goes over the APB port: 0x0 check enable, 0x4 CRC seed.
// Throughput and timing:
//   One byte per cycle while o_stall is low. The result is registered: it
//   appears on the outputs in the cycle after the last byte of its frame
//   is accepted; the CRC update is a two-nibble table lookup that fits
//   between the state registers and the output register.
// Reset:
//   Synchronous, active low. Clears the byte counter and the output valid
//   flag and restores checking enabled with seed 0xFF.
// Stall:
//   While the output register holds an untaken result, bytes that complete
//   no frame are still accepted; a frame's last byte waits until the
//   result register frees up.
module sensor_frame_crc8_checker
    import sfcrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_mode,
    // frame result
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_first_word,
    output logic [15:0] o_second_word,
    output logic        o_frame_valid,
    output logic        o_frame_kind
);

    // configuration registers
    logic       r_check_en;
    logic [7:0] r_crc_init;

    // frame state
    logic [2:0]  r_pos,   n_pos;
    logic [7:0]  r_crc,   n_crc;
    logic [15:0] r_word1, n_word1;
    logic [7:0]  r_hi,    n_hi;
    logic [15:0] r_word2, n_word2;
    logic        r_good1, n_good1;
    logic        r_kind,  n_kind;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_w1, r_out_w2;
    logic        r_out_good, r_out_kind;

    logic       cfg_wr;
    logic       in_acc;
    logic [2:0] pos_eff;
    logic       kind_eff;
    logic       restart;
    logic [7:0] crc_next;
    logic       crc_match;
    logic       emits;

    // Write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en <= CHECK_EN_RST;
            r_crc_init <= CRC_INIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CHECK_EN: r_check_en <= pwdata[0];
                REG_INIT_VAL: r_crc_init <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[2])
            REG_CHECK_EN: prdata = {31'd0, r_check_en};
            REG_INIT_VAL: prdata = {24'd0, r_crc_init};
            default:      prdata = 32'd0;
        endcase
    end

    // Effective position and kind; a frame start restarts the counter
    always_comb begin
        pos_eff  = i_frame_start ? POS_W1_HI : r_pos;
        if (pos_eff > POS_W2_CRC) begin
            pos_eff = POS_W1_HI;
        end
        kind_eff = i_frame_start ? i_mode : r_kind;
    end

    assign restart   = (pos_eff == POS_W1_HI) || (pos_eff == POS_W2_HI);
    assign crc_match = !r_check_en || (r_crc == i_data_byte);
    assign emits     = (pos_eff == POS_W2_CRC) ||
                       ((pos_eff == POS_W1_CRC) && (kind_eff == KIND_STATUS));

    sfcrc_crc8 u_crc8 (
        .i_seed_init (r_crc_init),
        .i_seed_run  (r_crc),
        .i_restart   (restart),
        .i_data      (i_data_byte),
        .o_crc       (crc_next)
    );

    // Hold only a frame-ending byte while the result register is blocked
    assign o_stall = r_out_valid && i_stall && emits;
    assign in_acc  = i_valid && !o_stall;

    // Advance the frame state for one byte
    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_word1 = r_word1;
        n_hi    = r_hi;
        n_word2 = r_word2;
        n_good1 = r_good1;
        n_kind  = kind_eff;
        case (pos_eff)
            POS_W1_HI: begin
                n_good1 = 1'b1;
                n_crc   = crc_next;
                n_word1 = {i_data_byte, 8'h00};
                n_pos   = POS_W1_LO;
            end
            POS_W1_LO: begin
                n_crc   = crc_next;
                n_word1 = {r_word1[15:8], i_data_byte};
                n_pos   = POS_W1_CRC;
            end
            POS_W1_CRC: begin
                if (kind_eff == KIND_STATUS) begin
                    n_pos = POS_W1_HI;
                end else begin
                    n_good1 = crc_match;
                    n_pos   = POS_W2_HI;
                end
            end
            POS_W2_HI: begin
                n_crc = crc_next;
                n_hi  = i_data_byte;
                n_pos = POS_W2_LO;
            end
            POS_W2_LO: begin
                n_crc   = crc_next;
                n_word2 = {r_hi, i_data_byte};
                n_pos   = POS_W2_CRC;
            end
            default: begin
                n_pos = POS_W1_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_W1_HI;
            r_crc   <= CRC_INIT_RST;
            r_word1 <= 16'd0;
            r_hi    <= 8'd0;
            r_word2 <= 16'd0;
            r_good1 <= 1'b1;
            r_kind  <= KIND_MEAS;
        end else if (in_acc) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_word1 <= n_word1;
            r_hi    <= n_hi;
            r_word2 <= n_word2;
            r_good1 <= n_good1;
            r_kind  <= n_kind;
        end
    end

    // Load the result register on a frame end, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && emits) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emits) begin
            r_out_w1   <= r_word1;
            r_out_kind <= kind_eff;
            if (kind_eff == KIND_STATUS) begin
                r_out_w2   <= 16'd0;
                r_out_good <= crc_match;
            end else begin
                r_out_w2   <= r_word2;
                r_out_good <= crc_match && r_good1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_first_word  = r_out_w1;
    assign o_second_word = r_out_w2;
    assign o_frame_valid = r_out_good;
    assign o_frame_kind  = r_out_kind;

    `include "assert_macros.svh"

    `SFC_ASSERT_IMPL(a_pos_range, 1'b1, r_pos <= POS_W2_CRC)
    `SFC_ASSERT_IMPL(a_status_w2_zero, r_out_valid && (r_out_kind == KIND_STATUS),
                     r_out_w2 == 16'd0)
    `SFC_ASSERT_IMPL(a_stall_only_full, o_stall, r_out_valid && i_stall)
    `SFC_ASSERT_NEXT(a_emit_loads, in_acc && emits, r_out_valid)

endmodule

// ===== sv/sfcrc_crc8.sv =====
// CRC-8 byte update with seed select between restart value and running CRC.
module sfcrc_crc8
    import sfcrc_pkg::*;
(
    input  logic [7:0] i_seed_init,
    input  logic [7:0] i_seed_run,
    input  logic       i_restart,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    logic [7:0] seed;

    // Pick the seed, then fold in the byte
    assign seed  = i_restart ? i_seed_init : i_seed_run;
    assign o_crc = crc8_update(seed, i_data);

endmodule

// ===== tb/sensor_frame_crc8_checker_test.sv =====
// Testbench for the sensor frame CRC-8 checker: directed and random frames against a CRC predictor.
`timescale 1ns / 1ps

module sensor_frame_crc8_checker_test
    import sfcrc_pkg::*;
();

    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam int         CYCLE_CAP  = 200000;
    localparam int         SETTLE_CAP = 5000;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       mode;
    } t_byte_req;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
        logic        valid;
        logic        kind;
    } t_frame_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_frame_start = 1'b0;
    logic        i_mode = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_first_word;
    logic [15:0] o_second_word;
    logic        o_frame_valid;
    logic        o_frame_kind;

    // Request traffic and expected frames
    t_byte_req  byte_queue[$];
    t_frame_res frames_due[$];
    t_byte_req  on_bus;
    int         items_left = 0;
    int         items_sent = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         errors = 0;
    int         cycles = 0;

    // Predictor copy of the registers and the frame state
    logic        cfg_check = CHECK_EN_RST;
    logic [7:0]  cfg_seed = CRC_INIT_RST;
    logic [2:0]  fr_pos = POS_W1_HI;
    logic [7:0]  fr_crc = CRC_INIT_RST;
    logic [15:0] fr_first = '0;
    logic [7:0]  fr_high = '0;
    logic [15:0] fr_second = '0;
    logic        fr_first_ok = 1'b1;
    logic        fr_kind = KIND_MEAS;

    sensor_frame_crc8_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_mode        (i_mode),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_first_word  (o_first_word),
        .o_second_word (o_second_word),
        .o_frame_valid (o_frame_valid),
        .o_frame_kind  (o_frame_kind)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bit-serial CRC-8, MSB first, no final XOR
    function automatic logic [7:0] crc8_bits(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Advance the frame state by one byte; queue a frame when one completes
    function automatic void assemble_frame(input t_byte_req r);
        logic [2:0] pos;
        logic       good;
        t_frame_res res;
        if (r.start) begin
            fr_pos  = POS_W1_HI;
            fr_kind = r.mode;
        end
        pos  = (fr_pos > POS_W2_CRC) ? POS_W1_HI : fr_pos;
        good = !cfg_check || (fr_crc == r.data);
        res  = '0;
        case (pos)
            POS_W1_HI: begin
                fr_first_ok = 1'b1;
                fr_crc      = crc8_bits(cfg_seed, r.data);
                fr_first    = {r.data, 8'h00};
                fr_pos      = POS_W1_LO;
            end
            POS_W1_LO: begin
                fr_crc        = crc8_bits(fr_crc, r.data);
                fr_first[7:0] = r.data;
                fr_pos        = POS_W1_CRC;
            end
            POS_W1_CRC: begin
                if (fr_kind == KIND_STATUS) begin
                    res.first = fr_first;
                    res.valid = good;
                    res.kind  = KIND_STATUS;
                    frames_due.push_back(res);
                    fr_pos = POS_W1_HI;
                end else begin
                    fr_first_ok = good;
                    fr_pos      = POS_W2_HI;
                end
            end
            POS_W2_HI: begin
                fr_crc  = crc8_bits(cfg_seed, r.data);
                fr_high = r.data;
                fr_pos  = POS_W2_LO;
            end
            POS_W2_LO: begin
                fr_crc    = crc8_bits(fr_crc, r.data);
                fr_second = {fr_high, r.data};
                fr_pos    = POS_W2_CRC;
            end
            default: begin
                res.first  = fr_first;
                res.second = fr_second;
                res.valid  = good && fr_first_ok;
                res.kind   = KIND_MEAS;
                frames_due.push_back(res);
                fr_pos = POS_W1_HI;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Register write: setup then access phase
    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHECK_EN: cfg_check = val[0];
            REG_INIT_VAL: cfg_seed  = val[7:0];
        endcase
    endtask

    task automatic push_byte(input logic [7:0] d, input logic st, input logic md);
        t_byte_req r;
        r.data  = d;
        r.start = st;
        r.mode  = md;
        byte_queue.push_back(r);
        items_left++;
        items_sent++;
    endtask

    // Queue a whole frame; bad[0] / bad[1] corrupt the first / second CRC byte
    task automatic push_frame(input logic kind, input logic st, input logic [1:0] bad,
                              input logic [15:0] w1, input logic [15:0] w2);
        logic [7:0] c;
        logic [7:0] flip;
        flip = 8'($urandom_range(255, 1));
        c = crc8_bits(crc8_bits(cfg_seed, w1[15:8]), w1[7:0]);
        push_byte(w1[15:8], st, st ? kind : logic'($urandom_range(1)));
        push_byte(w1[7:0], 1'b0, logic'($urandom_range(1)));
        push_byte(bad[0] ? c ^ flip : c, 1'b0, logic'($urandom_range(1)));
        if (kind == KIND_MEAS) begin
            c = crc8_bits(crc8_bits(cfg_seed, w2[15:8]), w2[7:0]);
            push_byte(w2[15:8], 1'b0, logic'($urandom_range(1)));
            push_byte(w2[7:0], 1'b0, logic'($urandom_range(1)));
            push_byte(bad[1] ? c ^ flip : c, 1'b0, logic'($urandom_range(1)));
        end
    endtask

    function automatic logic [15:0] rand_word();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Mostly well-formed frames, some cut short, some stray bytes
    task automatic run_traffic(input int n);
        int   goal;
        int   sel;
        logic aligned;
        logic kind;
        logic st;
        goal    = items_sent + n;
        aligned = 1'b0;
        kind    = KIND_MEAS;
        while (items_sent < goal) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                st = !aligned || ($urandom_range(3) != 0);
                if (st)
                    kind = logic'($urandom_range(1));
                push_frame(kind, st, {logic'($urandom_range(99) < 15),
                                      logic'($urandom_range(99) < 15)},
                           rand_word(), rand_word());
                aligned = 1'b1;
            end else if (sel < 90) begin
                kind = logic'($urandom_range(1));
                push_byte(8'($urandom_range(255)), 1'b1, kind);
                repeat ($urandom_range(4))
                    push_byte(8'($urandom_range(255)), 1'b0, logic'($urandom_range(1)));
                aligned = 1'b0;
            end else begin
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                          logic'($urandom_range(1)));
                aligned = 1'b0;
            end
        end
    endtask

    // Hold until every request is taken and every frame has come back, or SETTLE_CAP runs out
    task automatic settle();
        int waited;
        waited = 0;
        while (items_left != 0) @(posedge i_clk);
        while (frames_due.size() != 0 && waited < SETTLE_CAP) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Driver: present the next request when the slot is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                assemble_frame(on_bus);
                items_left = items_left - 1;
            end
            if (!i_valid || !o_stall) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = byte_queue.pop_front();
                    i_data_byte   <= on_bus.data;
                    i_frame_start <= on_bus.start;
                    i_mode        <= on_bus.mode;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken frame with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (frames_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame %h %h", o_first_word,
                                            o_second_word));
                end else begin
                    want = frames_due.pop_front();
                    if (o_first_word !== want.first)
                        flag_mismatch($sformatf("first_word %h, want %h", o_first_word,
                                                want.first));
                    if (o_second_word !== want.second)
                        flag_mismatch($sformatf("second_word %h, want %h", o_second_word,
                                                want.second));
                    if (o_frame_valid !== want.valid)
                        flag_mismatch($sformatf("frame_valid %b, want %b", o_frame_valid,
                                                want.valid));
                    if (o_frame_kind !== want.kind)
                        flag_mismatch($sformatf("frame_kind %b, want %b", o_frame_kind,
                                                want.kind));
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [15:0] w1;
        logic [15:0] w2;
        logic [7:0]  c;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at reset settings, no idling
        push_frame(KIND_STATUS, 1'b1, 2'b00, 16'hBEEF, 16'h0000);
        push_frame(KIND_MEAS, 1'b1, 2'b00, 16'h0000, 16'hFFFF);
        push_frame(KIND_MEAS, 1'b1, 2'b01, 16'hFFFF, 16'h0000);
        push_frame(KIND_STATUS, 1'b1, 2'b01, 16'h8001, 16'h0000);
        // restart in mid-frame drops the partial frame
        push_byte(8'hA5, 1'b1, KIND_MEAS);
        push_byte(8'h5A, 1'b0, KIND_STATUS);
        push_frame(KIND_STATUS, 1'b1, 2'b00, 16'h1234, 16'h0000);
        // no frame start: counter wraps and keeps the latched kind
        push_frame(KIND_STATUS, 1'b0, 2'b00, 16'h7FFE, 16'h0000);
        settle();

        // Checking off, zero seed, sender idling
        apb_write(REG_CHECK_EN, 32'd0);
        apb_write(REG_INIT_VAL, 32'h00);
        send_idle_pct = 62;
        run_traffic(110);
        settle();

        // Checking on, zero seed, receiver stalling
        apb_write(REG_CHECK_EN, 32'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        run_traffic(110);
        // bad first CRC, then checking off and a new seed before the second word
        w1 = rand_word();
        w2 = rand_word();
        c  = crc8_bits(crc8_bits(cfg_seed, w1[15:8]), w1[7:0]);
        push_byte(w1[15:8], 1'b1, KIND_MEAS);
        push_byte(w1[7:0], 1'b0, logic'($urandom_range(1)));
        push_byte(~c, 1'b0, logic'($urandom_range(1)));
        settle();
        apb_write(REG_CHECK_EN, 32'd0);
        apb_write(REG_INIT_VAL, $urandom_range(254, 1));
        c = crc8_bits(crc8_bits(cfg_seed, w2[15:8]), w2[7:0]);
        push_byte(w2[15:8], 1'b0, logic'($urandom_range(1)));
        push_byte(w2[7:0], 1'b0, logic'($urandom_range(1)));
        push_byte(c, 1'b0, logic'($urandom_range(1)));
        settle();

        // Checking on, random seed, both sides idling, full drain halfway
        apb_write(REG_CHECK_EN, 32'd1);
        apb_write(REG_INIT_VAL, $urandom_range(254, 1));
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        run_traffic(70);
        settle();
        run_traffic(70);
        settle();

        // Back to reset settings, no idling
        apb_write(REG_INIT_VAL, 32'hFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(120);
        settle();

        if (frames_due.size() != 0)
            flag_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
